[rtl/elp_pkg.sv]
// ============================================================================
// elp_pkg - edge list line parser shared definitions
// Beat types, event codes, character codes and parser state encodings.
// ============================================================================
`default_nettype none

package elp_pkg;

    // default width of the saturating line counter
    localparam int LINE_COUNT_BITS_DEF = 32;

    // field widths
    localparam int CHAR_W = 21;
    localparam int LINE_W = 32;

    // most result beats one input beat can cause
    localparam int MAX_RESULTS = 3;

    // result queue geometry
    localparam int RQ_DEPTH = 8;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // event kinds
    localparam logic [2:0] EV_CHAR   = 3'd0;
    localparam logic [2:0] EV_FEND   = 3'd1;
    localparam logic [2:0] EV_EDGE   = 3'd2;
    localparam logic [2:0] EV_ACCEPT = 3'd3;
    localparam logic [2:0] EV_ERROR  = 3'd4;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SPACE  = 21'd32;
    localparam logic [CHAR_W-1:0] CH_TAB    = 21'd9;
    localparam logic [CHAR_W-1:0] CH_CR     = 21'd13;
    localparam logic [CHAR_W-1:0] CH_LF     = 21'd10;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 21'd34;
    localparam logic [CHAR_W-1:0] CH_BACKSL = 21'd92;

    // lexer phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CR,
        PH_WORD,
        PH_QUOTE,
        PH_ESC
    } t_lex_phase;

    // position in the line grammar
    typedef enum logic [1:0] {
        GP_SRC,
        GP_DST,
        GP_LABEL,
        GP_EOL
    } t_gram_pos;

    // input beat
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_input;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [2:0]        event_kind;
        logic [1:0]        field_role;
        logic [CHAR_W-1:0] out_char;
        logic [LINE_W-1:0] line_number;
        logic              last_of_run;
    } t_out_beat;

    // group of result beats handed from parser to queue
    typedef struct packed {
        logic [1:0]                        count;
        t_out_beat [MAX_RESULTS-1:0]       beats;
    } t_push;

    // build one result beat, last flag cleared
    function automatic t_out_beat mk_beat(
        input logic [2:0]        kind,
        input logic [1:0]        role,
        input logic [CHAR_W-1:0] ch,
        input logic [LINE_W-1:0] line
    );
        t_out_beat b;
        b.event_kind  = kind;
        b.field_role  = role;
        b.out_char    = ch;
        b.line_number = line;
        b.last_of_run = 1'b0;
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/elp_stream_if.sv]
// ============================================================================
// elp_stream_if - valid/ready stream channel
// Carries one payload beat per handshake, payload type set per instance.
// ============================================================================
`default_nettype none

interface elp_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/elp_parser.sv]
// ============================================================================
// elp_parser - input register and single-pass line parser
// Registers one input beat, decodes it against lexer and grammar state and
// produces up to three result beats per parsed beat for the result queue.
// ============================================================================
`default_nettype none

module elp_parser
    import elp_pkg::*;
#(
    parameter int LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    elp_stream_if.sink   i_in,
    input  wire logic    i_room,
    output t_push        o_push
);

    // input register
    logic     r_in_valid;
    t_in_beat r_in;
    logic     w_fire;

    // parser state
    t_lex_phase                 r_phase, n_phase;
    t_gram_pos                  r_gp, n_gp;
    logic [LINE_COUNT_BITS-1:0] r_line, n_line;
    logic                       r_fin, n_fin;
    logic                       r_err, n_err;

    // decoded actions
    logic              d_fend;
    logic [1:0]        d_nchar;
    logic [CHAR_W-1:0] d_ch_a;
    logic [CHAR_W-1:0] d_ch_b;
    logic              d_edge;
    logic              d_accept;
    logic              d_error;
    logic              d_nl;
    t_gram_pos         d_role;

    logic [LINE_W-1:0] w_line_old;
    logic [LINE_W-1:0] w_line_new;
    logic [LINE_W-1:0] w_line_evt;

    // stage handshake
    assign w_fire     = r_in_valid && i_room;
    assign i_in.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.payload;
        end
    end

    // state registers, advanced once per parsed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_gp    <= GP_SRC;
            r_line  <= LINE_COUNT_BITS'(1);
            r_fin   <= 1'b0;
            r_err   <= 1'b0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_gp    <= n_gp;
            r_line  <= n_line;
            r_fin   <= n_fin;
            r_err   <= n_err;
        end
    end

    // decode and next state
    always_comb begin
        logic [CHAR_W-1:0] c;
        logic              eoi;
        logic              c_word;
        logic              do_idle;
        logic              do_end;
        t_gram_pos         gp1;

        c       = r_in.char_code;
        eoi     = r_in.end_of_input;
        c_word  = c > CH_SPACE;
        do_idle = 1'b0;
        do_end  = 1'b0;

        d_fend   = 1'b0;
        d_nchar  = 2'd0;
        d_ch_a   = c;
        d_ch_b   = c;
        d_edge   = 1'b0;
        d_accept = 1'b0;
        d_error  = 1'b0;
        d_nl     = 1'b0;

        n_phase = r_phase;
        n_line  = r_line;
        n_fin   = r_fin;
        n_err   = r_err;

        // lexer phase
        if (!r_err && !r_fin) begin
            if (eoi) begin
                case (r_phase)
                    PH_WORD: begin
                        d_fend = 1'b1;
                        do_end = 1'b1;
                    end
                    PH_IDLE: begin
                        do_end = 1'b1;
                    end
                    default: begin
                        d_error = 1'b1;
                    end
                endcase
            end else begin
                case (r_phase)
                    PH_WORD: begin
                        if (c_word) begin
                            d_nchar = 2'd1;
                        end else begin
                            d_fend  = 1'b1;
                            do_idle = 1'b1;
                        end
                    end
                    PH_CR: begin
                        if (c == CH_LF) begin
                            d_nl = 1'b1;
                        end else begin
                            d_error = 1'b1;
                        end
                    end
                    PH_QUOTE: begin
                        if (c == CH_QUOTE) begin
                            d_fend = 1'b1;
                        end else if (c == CH_BACKSL) begin
                            n_phase = PH_ESC;
                        end else begin
                            d_nchar = 2'd1;
                        end
                    end
                    PH_ESC: begin
                        if (c == CH_QUOTE) begin
                            d_nchar = 2'd1;
                            d_ch_a  = CH_QUOTE;
                        end else begin
                            d_nchar = 2'd2;
                            d_ch_a  = CH_BACKSL;
                            d_ch_b  = c;
                        end
                        n_phase = PH_QUOTE;
                    end
                    default: begin
                        do_idle = 1'b1;
                    end
                endcase
            end
        end

        // field end moves the grammar on
        gp1 = r_gp;
        if (d_fend) begin
            n_phase = PH_IDLE;
            if (r_gp != GP_EOL) begin
                gp1 = t_gram_pos'(r_gp + 2'd1);
            end
        end
        d_role = gp1;

        // character between tokens
        if (do_idle) begin
            if (c inside {CH_SPACE, CH_TAB}) begin
                // separator, nothing to do
            end else if (c == CH_CR) begin
                n_phase = PH_CR;
            end else if (c == CH_LF) begin
                d_nl = 1'b1;
            end else if (c == CH_QUOTE) begin
                if (gp1 == GP_EOL) begin
                    d_error = 1'b1;
                end else begin
                    n_phase = PH_QUOTE;
                end
            end else if (c_word) begin
                if (gp1 == GP_EOL) begin
                    d_error = 1'b1;
                end else begin
                    d_nchar = 2'd1;
                    n_phase = PH_WORD;
                end
            end else begin
                d_error = 1'b1;
            end
        end

        // newline: count first, then check the grammar
        if (d_nl) begin
            if (!(&r_line)) begin
                n_line = r_line + LINE_COUNT_BITS'(1);
            end
            n_phase = PH_IDLE;
            if (gp1 == GP_LABEL || gp1 == GP_EOL) begin
                d_edge = 1'b1;
                gp1    = GP_SRC;
            end else begin
                d_error = 1'b1;
            end
        end

        // end of input
        if (do_end) begin
            if (gp1 == GP_DST) begin
                d_error = 1'b1;
            end else begin
                d_edge   = gp1 != GP_SRC;
                d_accept = 1'b1;
                n_fin    = 1'b1;
            end
        end

        if (d_error) begin
            n_err = 1'b1;
        end
        n_gp = gp1;
    end

    // line number as reported, saturated to the field width
    generate
        if (LINE_COUNT_BITS > LINE_W) begin : g_line_sat
            assign w_line_old = (|r_line[LINE_COUNT_BITS-1:LINE_W]) ?
                                '1 : r_line[LINE_W-1:0];
            assign w_line_new = (|n_line[LINE_COUNT_BITS-1:LINE_W]) ?
                                '1 : n_line[LINE_W-1:0];
        end else begin : g_line_ext
            assign w_line_old = LINE_W'(r_line);
            assign w_line_new = LINE_W'(n_line);
        end
    endgenerate

    assign w_line_evt = d_nl ? w_line_new : w_line_old;

    // result beats in event order
    always_comb begin
        logic [1:0] k;

        k             = 2'd0;
        o_push.beats  = '0;
        if (d_fend) begin
            o_push.beats[k] = mk_beat(EV_FEND, r_gp, '0, w_line_old);
            k = k + 2'd1;
        end
        if (d_nchar != 2'd0) begin
            o_push.beats[k] = mk_beat(EV_CHAR, d_role, d_ch_a, w_line_old);
            k = k + 2'd1;
        end
        if (d_nchar == 2'd2) begin
            o_push.beats[k] = mk_beat(EV_CHAR, d_role, d_ch_b, w_line_old);
            k = k + 2'd1;
        end
        if (d_edge) begin
            o_push.beats[k] = mk_beat(EV_EDGE, 2'd0, '0, w_line_evt);
            k = k + 2'd1;
        end
        if (d_accept) begin
            o_push.beats[k] = mk_beat(EV_ACCEPT, 2'd0, '0, w_line_old);
            k = k + 2'd1;
        end
        if (d_error) begin
            o_push.beats[k] = mk_beat(EV_ERROR, 2'd0, '0, w_line_evt);
            k = k + 2'd1;
        end
        if (k != 2'd0) begin
            o_push.beats[k - 2'd1].last_of_run = 1'b1;
        end
        o_push.count = w_fire ? k : 2'd0;
    end

endmodule

`default_nettype wire

[rtl/elp_result_queue.sv]
// ============================================================================
// elp_result_queue - result beat queue
// Takes up to three result beats per cycle and hands out one beat per
// handshake; reports room when a full group of beats still fits.
// ============================================================================
`default_nettype none

module elp_result_queue
    import elp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  t_push        i_push,
    output logic         o_room,
    elp_stream_if.source o_out
);

    t_out_beat           r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_wr, n_wr;
    logic [RQ_PTR_W-1:0] r_rd, n_rd;
    logic [RQ_CNT_W-1:0] r_count, n_count;
    logic                w_pop;

    // output side
    assign o_out.valid   = r_count != '0;
    assign o_out.payload = r_mem[r_rd];
    assign w_pop         = o_out.valid && o_out.ready;
    assign o_room        = r_count <= RQ_CNT_W'(RQ_DEPTH - MAX_RESULTS);

    // pointer and fill arithmetic
    always_comb begin
        n_wr    = r_wr + RQ_PTR_W'(i_push.count);
        n_rd    = w_pop ? r_rd + RQ_PTR_W'(1) : r_rd;
        n_count = r_count + RQ_CNT_W'(i_push.count) - RQ_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage writes, one per pushed beat
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RESULTS; j++) begin
            if (2'(j) < i_push.count) begin
                r_mem[r_wr + RQ_PTR_W'(j)] <= i_push.beats[j];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/edge_list_line_parser.sv]
// ============================================================================
// edge_list_line_parser - edge list text line parser
// Parses one character per beat into field, edge, end and error events.
// ============================================================================
//
//  channel | dir | payload                                         | handshake
//  --------+-----+-------------------------------------------------+----------
//  i_in    | in  | char_code, end_of_input                         | valid/ready
//  o_out   | out | event_kind, field_role, out_char, line_number,  | valid/ready
//          |     | last_of_run                                     |
//
//  One input beat per cycle is accepted while the result queue has room; it
//  waits in the input register, is parsed there and written to the queue.
//  A beat gives zero to three result beats; the eight-entry result queue
//  drains one per ready cycle, so input stalls only while it holds over five.
//  Reset (synchronous, active low) clears the parser state, line count to one.
//  After an error or an accepted end all further input beats are dropped.
// ============================================================================
`default_nettype none

module edge_list_line_parser
    import elp_pkg::*;
#(
    parameter int LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    elp_stream_if.sink   i_in,
    elp_stream_if.source o_out
);

    t_push w_push;
    logic  w_room;

    // parser with input register
    elp_parser #(
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    // result beat queue
    elp_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
